// ===== design/ppa_pkg.sv =====
// ppa_pkg: shared types, constants and the control store of the pid percent actuator
// holds the microcode table, control word layout and datapath strobe struct
// no dependencies
`timescale 1ns / 1ps

package ppa_pkg;

    // default fixed-point layout
    localparam int PPA_FRAC_BITS = 16;
    localparam int PPA_SUM_WIDTH = 48;

    // shared multiplier and constant divider geometry
    localparam int MUL_W     = 34;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int QUO_W     = 33;
    localparam int DIV_BITS  = 3;
    localparam int DIV_STEPS = QUO_W / DIV_BITS;
    localparam int LOOP_W    = $clog2(DIV_STEPS);

    // control store addressing
    localparam int PC_W = 4;
    localparam logic [PC_W-1:0] UC_WAIT_IN  = 4'd0;
    localparam logic [PC_W-1:0] UC_KP_E     = 4'd1;
    localparam logic [PC_W-1:0] UC_KI_LO    = 4'd2;
    localparam logic [PC_W-1:0] UC_KI_HI    = 4'd3;
    localparam logic [PC_W-1:0] UC_KD_D     = 4'd4;
    localparam logic [PC_W-1:0] UC_ACC_LAST = 4'd5;
    localparam logic [PC_W-1:0] UC_PCT      = 4'd6;
    localparam logic [PC_W-1:0] UC_MAP_MUL  = 4'd7;
    localparam logic [PC_W-1:0] UC_DIV_LOAD = 4'd8;
    localparam logic [PC_W-1:0] UC_DIV_STEP = 4'd9;
    localparam logic [PC_W-1:0] UC_OUT      = 4'd10;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_KP     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KI_TS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KD_TS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER  = 3'd5;

    typedef enum logic [1:0] {
        WAIT_NONE,
        WAIT_INPUT,
        WAIT_LOOP,
        WAIT_OUTPUT
    } ppa_wait_t;

    typedef enum logic [2:0] {
        MUL_IDLE,
        MUL_KP_E,
        MUL_KI_LO,
        MUL_KI_HI,
        MUL_KD_D,
        MUL_T_SPAN
    } ppa_mul_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD_OFF,
        ACC_ADD,
        ACC_ADD_HI
    } ppa_acc_op_t;

    // one word of the control store
    typedef struct packed {
        ppa_wait_t       wait_cond;
        logic            jump;
        logic [PC_W-1:0] jump_addr;
        ppa_mul_sel_t    mul_sel;
        ppa_acc_op_t     acc_op;
        logic            pct_en;
        logic            state_upd;
        logic            div_load;
        logic            div_step;
        logic            out_wr;
    } ppa_ucode_t;

    // strobes from the sequencer to the datapath
    typedef struct packed {
        ppa_mul_sel_t mul_sel;
        ppa_acc_op_t  acc_op;
        logic         pct_en;
        logic         state_upd;
        logic         div_load;
        logic         div_step;
        logic         in_load;
        logic         out_load;
    } ppa_dp_ctrl_t;

    // configuration registers as seen by the datapath
    typedef struct packed {
        logic signed [31:0] kp_gain;
        logic signed [31:0] ki_ts_gain;
        logic signed [31:0] kd_over_ts_gain;
        logic signed [23:0] offset_pct;
        logic signed [31:0] lower_limit;
        logic signed [31:0] upper_limit;
    } ppa_cfg_t;

    // control store contents
    function automatic ppa_ucode_t ppa_ucode(input logic [PC_W-1:0] pc);
        ppa_ucode_t w;
        w = '0;
        unique case (pc)
            UC_WAIT_IN: begin
                w.wait_cond = WAIT_INPUT;
            end
            UC_KP_E: begin
                w.mul_sel = MUL_KP_E;
                w.acc_op  = ACC_LOAD_OFF;
            end
            UC_KI_LO: begin
                w.mul_sel = MUL_KI_LO;
                w.acc_op  = ACC_ADD;
            end
            UC_KI_HI: begin
                w.mul_sel = MUL_KI_HI;
                w.acc_op  = ACC_ADD;
            end
            UC_KD_D: begin
                w.mul_sel = MUL_KD_D;
                w.acc_op  = ACC_ADD_HI;
            end
            UC_ACC_LAST: begin
                w.acc_op = ACC_ADD;
            end
            UC_PCT: begin
                w.pct_en    = 1'b1;
                w.state_upd = 1'b1;
            end
            UC_MAP_MUL: begin
                w.mul_sel = MUL_T_SPAN;
            end
            UC_DIV_LOAD: begin
                w.div_load = 1'b1;
            end
            UC_DIV_STEP: begin
                w.div_step  = 1'b1;
                w.wait_cond = WAIT_LOOP;
            end
            UC_OUT: begin
                w.out_wr    = 1'b1;
                w.wait_cond = WAIT_OUTPUT;
                w.jump      = 1'b1;
                w.jump_addr = UC_WAIT_IN;
            end
            default: begin
                w.jump      = 1'b1;
                w.jump_addr = UC_WAIT_IN;
            end
        endcase
        return w;
    endfunction

endpackage

// ===== design/pid_percent_actuator_core.sv =====
// pid_percent_actuator_core: top level, configuration registers and result register
// instantiates ppa_sequencer and ppa_datapath; depends on ppa_pkg
`timescale 1ns / 1ps

// Positional PID controller with a percent-domain output mapped onto a drive range.
// Input channel: in_valid / in_ready carry one beat of error_sample (Q16.16) and
// clear_first, which zeroes the error sum and previous error before the step.
// Output channel: out_valid / out_ready carry one beat of drive and clamped per input.
// Configuration: cfg_we writes cfg_wdata into the register at cfg_index (gains,
// offset, lower and upper limit); unlisted indexes are ignored. Write only while idle.
// The core takes no new input while an item is in progress; in_ready rises in the
// cycle after the result is registered. The microcode program makes five passes
// through one shared 34x34 multiplier and the accumulator, a clamp step, then 11
// steps of the divide-by-200-percent unit that resolves three quotient bits per
// cycle.
// The result register lets a new item be taken while the last result waits; if the
// receiver still holds off the earlier result when the next one is ready, the
// sequencer waits on its final step.
// Reset clears the configuration registers, the error sum and the previous error,
// and returns the sequencer to the input wait step.

module pid_percent_actuator_core import ppa_pkg::*;
#(
    parameter int FRAC_BITS = PPA_FRAC_BITS,
    parameter int SUM_WIDTH = PPA_SUM_WIDTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic signed [31:0]   error_sample,
    input  logic                 clear_first,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [31:0]   drive,
    output logic                 clamped,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_wdata
);

    ppa_cfg_t           cfg_reg;
    ppa_cfg_t           cfg_next;
    ppa_dp_ctrl_t       dp_ctrl;
    logic               out_busy;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic signed [31:0] drive_reg;
    logic               clamped_reg;
    logic signed [31:0] drive_value;
    logic               clamp_flag;

    // configuration write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_KP:     cfg_next.kp_gain         = cfg_wdata;
                CFG_KI_TS:  cfg_next.ki_ts_gain      = cfg_wdata;
                CFG_KD_TS:  cfg_next.kd_over_ts_gain = cfg_wdata;
                CFG_OFFSET: cfg_next.offset_pct      = cfg_wdata[23:0];
                CFG_LOWER:  cfg_next.lower_limit     = cfg_wdata;
                CFG_UPPER:  cfg_next.upper_limit     = cfg_wdata;
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    // result register handshake
    assign out_busy = out_valid_reg && !out_ready;

    always_comb
    begin
        if (dp_ctrl.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (dp_ctrl.out_load)
        begin
            drive_reg   <= drive_value;
            clamped_reg <= clamp_flag;
        end
    end

    assign out_valid = out_valid_reg;
    assign drive     = drive_reg;
    assign clamped   = clamped_reg;

    ppa_sequencer u_seq
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .out_busy (out_busy),
        .dp_ctrl  (dp_ctrl)
    );

    ppa_datapath #(
        .FRAC_BITS (FRAC_BITS),
        .SUM_WIDTH (SUM_WIDTH)
    ) u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (dp_ctrl),
        .cfg          (cfg_reg),
        .error_sample (error_sample),
        .clear_first  (clear_first),
        .drive_value  (drive_value),
        .clamp_flag   (clamp_flag)
    );

endmodule

// ===== design/ppa_sequencer.sv =====
// ppa_sequencer: step counter, control store lookup and loop counter
// drives the datapath strobes; depends on ppa_pkg
`timescale 1ns / 1ps

module ppa_sequencer import ppa_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic         out_busy,
    output ppa_dp_ctrl_t dp_ctrl
);

    logic [PC_W-1:0]   pc_reg;
    logic [PC_W-1:0]   pc_next;
    logic [LOOP_W-1:0] loop_cnt_reg;
    logic [LOOP_W-1:0] loop_cnt_next;
    ppa_ucode_t        word;
    logic              hold;
    logic              in_fire;

    // current control word
    assign word = ppa_ucode(pc_reg);

    assign in_ready = (word.wait_cond == WAIT_INPUT);
    assign in_fire  = in_ready && in_valid;

    // stay on the step while its wait condition holds
    always_comb
    begin
        unique case (word.wait_cond)
            WAIT_INPUT:  hold = !in_valid;
            WAIT_LOOP:   hold = (loop_cnt_reg != '0);
            WAIT_OUTPUT: hold = out_busy;
            default:     hold = 1'b0;
        endcase
    end

    // next step address
    always_comb
    begin
        if (hold)
        begin
            pc_next = pc_reg;
        end
        else if (word.jump)
        begin
            pc_next = word.jump_addr;
        end
        else
        begin
            pc_next = pc_reg + 1'b1;
        end
    end

    // divider iteration count
    always_comb
    begin
        loop_cnt_next = loop_cnt_reg;
        if (word.div_load)
        begin
            loop_cnt_next = LOOP_W'(DIV_STEPS - 1);
        end
        else if (word.div_step && (loop_cnt_reg != '0))
        begin
            loop_cnt_next = loop_cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg       <= UC_WAIT_IN;
            loop_cnt_reg <= '0;
        end
        else
        begin
            pc_reg       <= pc_next;
            loop_cnt_reg <= loop_cnt_next;
        end
    end

    // datapath strobes
    always_comb
    begin
        dp_ctrl.mul_sel   = word.mul_sel;
        dp_ctrl.acc_op    = word.acc_op;
        dp_ctrl.pct_en    = word.pct_en;
        dp_ctrl.state_upd = word.state_upd;
        dp_ctrl.div_load  = word.div_load;
        dp_ctrl.div_step  = word.div_step;
        dp_ctrl.in_load   = in_fire;
        dp_ctrl.out_load  = word.out_wr && !out_busy;
    end

endmodule

// ===== design/ppa_datapath.sv =====
// ppa_datapath: shared multiplier, wide accumulator, clamp, constant divider and state
// works under strobes from ppa_sequencer; depends on ppa_pkg
`timescale 1ns / 1ps

module ppa_datapath import ppa_pkg::*;
#(
    parameter int FRAC_BITS = PPA_FRAC_BITS,
    parameter int SUM_WIDTH = PPA_SUM_WIDTH
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  ppa_dp_ctrl_t       ctrl,
    input  ppa_cfg_t           cfg,
    input  logic signed [31:0] error_sample,
    input  logic               clear_first,
    output logic signed [31:0] drive_value,
    output logic               clamp_flag
);

    localparam int ACC_W = SUM_WIDTH + 34;
    localparam int PCT_W = FRAC_BITS + 8;

    localparam logic signed [ACC_W-1:0] ACC_TOP = ACC_W'(100) <<< (2 * FRAC_BITS);
    localparam logic signed [ACC_W-1:0] ACC_BOT = -ACC_TOP;
    localparam logic signed [PCT_W-1:0] PCT_NEAR =
        PCT_W'(((64'd99999 << FRAC_BITS) + 64'd500) / 64'd1000);
    localparam logic signed [PCT_W-1:0] PCT_NEAR_NEG = -PCT_NEAR;
    localparam logic [PCT_W-1:0] PCT_BIAS = PCT_W'(100) << FRAC_BITS;
    localparam logic [PCT_W-1:0] DIV_D    = PCT_W'(200) << FRAC_BITS;
    localparam logic [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
    localparam logic [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

    logic signed [31:0]          e_reg;
    logic signed [SUM_WIDTH-1:0] sum_reg;
    logic signed [SUM_WIDTH-1:0] sum_next;
    logic signed [31:0]          prev_reg;
    logic signed [31:0]          prev_next;
    logic signed [PROD_W-1:0]    prod_reg;
    logic signed [ACC_W-1:0]     acc_reg;
    logic [PCT_W-1:0]            t_reg;
    logic                        clamp_reg;
    logic [PCT_W-1:0]            rem_reg;
    logic [QUO_W-1:0]            quo_reg;

    logic signed [63:0]          sum_ext;
    logic signed [32:0]          diff;
    logic signed [32:0]          span;
    logic [32:0]                 span_mag;
    logic signed [MUL_W-1:0]     mul_a;
    logic signed [MUL_W-1:0]     mul_b;
    logic signed [PROD_W-1:0]    mul_p;
    logic signed [ACC_W-1:0]     acc_shift;
    logic signed [PCT_W-1:0]     pct;
    logic                        over_top;
    logic                        under_bot;
    logic signed [SUM_WIDTH:0]   sum_wide;
    logic [PCT_W-1:0]            rem_v;
    logic [QUO_W-1:0]            quo_v;
    logic [PCT_W:0]              div_trial;
    logic [32:0]                 q_dir;

    assign sum_ext  = 64'(sum_reg);
    assign diff     = 33'(e_reg) - 33'(prev_reg);
    assign span     = 33'(cfg.upper_limit) - 33'(cfg.lower_limit);
    assign span_mag = span[32] ? (33'd0 - span) : span;

    // operand select for the shared multiplier
    always_comb
    begin
        case (ctrl.mul_sel)
            MUL_KP_E:
            begin
                mul_a = MUL_W'(cfg.kp_gain);
                mul_b = MUL_W'(e_reg);
            end
            MUL_KI_LO:
            begin
                mul_a = MUL_W'(cfg.ki_ts_gain);
                mul_b = $signed({2'b00, sum_ext[31:0]});
            end
            MUL_KI_HI:
            begin
                mul_a = MUL_W'(cfg.ki_ts_gain);
                mul_b = MUL_W'($signed(sum_ext[63:32]));
            end
            MUL_KD_D:
            begin
                mul_a = MUL_W'(cfg.kd_over_ts_gain);
                mul_b = MUL_W'(diff);
            end
            MUL_T_SPAN:
            begin
                mul_a = $signed(MUL_W'(t_reg));
                mul_b = $signed({1'b0, span_mag});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // percent from the accumulator, with clamp to just inside the band
    assign over_top  = (acc_reg > ACC_TOP);
    assign under_bot = (acc_reg < ACC_BOT);
    assign acc_shift = acc_reg >>> FRAC_BITS;

    always_comb
    begin
        if (over_top)
        begin
            pct = PCT_NEAR;
        end
        else if (under_bot)
        begin
            pct = PCT_NEAR_NEG;
        end
        else
        begin
            pct = acc_shift[PCT_W-1:0];
        end
    end

    // saturating error sum
    assign sum_wide = (SUM_WIDTH + 1)'(sum_reg) + (SUM_WIDTH + 1)'(e_reg);

    always_comb
    begin
        sum_next  = sum_reg;
        prev_next = prev_reg;
        if (ctrl.in_load && clear_first)
        begin
            sum_next  = '0;
            prev_next = '0;
        end
        else if (ctrl.state_upd)
        begin
            prev_next = e_reg;
            if (sum_wide[SUM_WIDTH] != sum_wide[SUM_WIDTH-1])
            begin
                sum_next = sum_wide[SUM_WIDTH] ? SUM_MIN : SUM_MAX;
            end
            else
            begin
                sum_next = sum_wide[SUM_WIDTH-1:0];
            end
        end
    end

    // divide by 200 percent, DIV_BITS quotient bits per step
    always_comb
    begin
        rem_v     = rem_reg;
        quo_v     = quo_reg;
        div_trial = '0;
        for (int i = 0; i < DIV_BITS; i++)
        begin
            div_trial = {rem_v, quo_v[QUO_W-1]};
            quo_v     = {quo_v[QUO_W-2:0], 1'b0};
            if (div_trial >= {1'b0, DIV_D})
            begin
                div_trial = div_trial - {1'b0, DIV_D};
                quo_v[0]  = 1'b1;
            end
            rem_v = div_trial[PCT_W-1:0];
        end
    end

    // controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg  <= '0;
            prev_reg <= '0;
        end
        else
        begin
            sum_reg  <= sum_next;
            prev_reg <= prev_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (ctrl.in_load)
        begin
            e_reg <= error_sample;
        end
        if (ctrl.mul_sel != MUL_IDLE)
        begin
            prod_reg <= mul_p;
        end
        case (ctrl.acc_op)
            ACC_LOAD_OFF: acc_reg <= ACC_W'(cfg.offset_pct) <<< FRAC_BITS;
            ACC_ADD:      acc_reg <= acc_reg + ACC_W'(prod_reg);
            ACC_ADD_HI:   acc_reg <= acc_reg + (ACC_W'(prod_reg) <<< 32);
            default:      acc_reg <= acc_reg;
        endcase
        if (ctrl.pct_en)
        begin
            t_reg     <= PCT_W'(pct) + PCT_BIAS;
            clamp_reg <= over_top || under_bot;
        end
        if (ctrl.div_load)
        begin
            rem_reg <= prod_reg[PCT_W+QUO_W-1:QUO_W];
            quo_reg <= prod_reg[QUO_W-1:0];
        end
        else if (ctrl.div_step)
        begin
            rem_reg <= rem_v;
            quo_reg <= quo_v;
        end
    end

    // map onto the limit range, direction from the span sign
    assign q_dir       = span[32] ? (33'd0 - quo_reg) : quo_reg;
    assign drive_value = cfg.lower_limit + $signed(q_dir[31:0]);
    assign clamp_flag  = clamp_reg;

endmodule

// ===== tb/tb_pid_percent_actuator_core.sv =====
// tb_pid_percent_actuator_core: self-checking testbench for the pid percent actuator core
// predicts drive and clamp flag per error beat and checks every result beat in order
// depends on ppa_pkg and pid_percent_actuator_core
`timescale 1ns / 1ps

module tb_pid_percent_actuator_core;
    import ppa_pkg::*;

    localparam int FRAC  = PPA_FRAC_BITS;
    localparam int SUM_W = PPA_SUM_WIDTH;

    // register indexes that map to nothing
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_B = 3'd7;

    // percent values in Q16.16
    localparam logic [31:0] PCT_100  = 32'h0064_0000;
    localparam logic [31:0] PCT_M100 = 32'hFF9C_0000;
    localparam longint PCT_LIMIT =
        (longint'(99999) * (longint'(1) <<< FRAC) + longint'(500)) / longint'(1000);

    localparam int RAND_PHASES  = 6;
    localparam int PHASE_ITEMS  = 300;
    localparam int SAT_ITEMS    = 65545;
    localparam int DRAIN_CYCLES = 30;
    localparam int HOLD_CYCLES  = 400;
    // the long integrator run takes most of the simulation time
    localparam longint RUN_LIMIT_NS = 64'd60_000_000;

    typedef enum int
    {
        PH_MODERATE,
        PH_OFFSET,
        PH_WILD,
        PH_REVERSED,
        PH_EQUAL,
        PH_EXTREME
    } phase_kind_t;

    typedef struct packed
    {
        logic [31:0] drive;
        logic        clamped;
    } drive_beat_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [31:0]          error_sample;
    logic                 clear_first;
    logic                 out_valid;
    logic                 out_ready;
    logic [31:0]          drive;
    logic                 clamped;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0]          cfg_wdata;

    // shadow of the configuration and the controller state
    logic signed [31:0]      kp_model;
    logic signed [31:0]      ki_model;
    logic signed [31:0]      kd_model;
    logic signed [23:0]      offset_model;
    logic signed [31:0]      lower_model;
    logic signed [31:0]      upper_model;
    logic signed [SUM_W-1:0] sum_model;
    logic signed [31:0]      prev_model;

    drive_beat_t pending_drive_q[$];
    drive_beat_t want_beat;
    int          fail_count;
    int          tx_idle_odds;
    int          rx_idle_odds;
    int          rx_hold_req;

    pid_percent_actuator_core dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .error_sample (error_sample),
        .clear_first  (clear_first),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .drive        (drive),
        .clamped      (clamped),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // one controller step: clear, wide sum of the terms, clamp, state update, map
    function automatic drive_beat_t predict_actuation(input logic signed [31:0] e,
                                                      input logic clr);
        logic signed [127:0] acc, bound, kp_w, ki_w, kd_w, off_w, e_w, p_w, s_w, pct_w;
        longint sum_next, sum_max, sum_min, pct, span, lo_w, hi_w, t, q, drv;
        drive_beat_t r;
        if (clr)
        begin
            sum_model  = '0;
            prev_model = '0;
        end
        kp_w  = kp_model;
        ki_w  = ki_model;
        kd_w  = kd_model;
        off_w = offset_model;
        e_w   = e;
        p_w   = prev_model;
        s_w   = sum_model;
        acc   = kp_w * e_w + ki_w * s_w + kd_w * (e_w - p_w) + (off_w <<< FRAC);
        bound = 128'sd100 <<< (2 * FRAC);
        r.clamped = 1'b0;
        if (acc > bound)
        begin
            pct       = PCT_LIMIT;
            r.clamped = 1'b1;
        end
        else if (acc < -bound)
        begin
            pct       = -PCT_LIMIT;
            r.clamped = 1'b1;
        end
        else
        begin
            pct_w = acc >>> FRAC;
            pct   = pct_w[63:0];
        end

        // error sum saturates at its own width
        sum_max  = (longint'(1) <<< (SUM_W - 1)) - 1;
        sum_min  = -sum_max - 1;
        sum_next = sum_model;
        sum_next = sum_next + e;
        if (sum_next > sum_max)
            sum_next = sum_max;
        else if (sum_next < sum_min)
            sum_next = sum_min;
        sum_model  = sum_next[SUM_W-1:0];
        prev_model = e;

        // linear map of [-100,100] onto [lower,upper], quotient toward zero
        lo_w = lower_model;
        hi_w = upper_model;
        span = hi_w - lo_w;
        t    = pct + (longint'(100) <<< FRAC);
        q    = (t * ((span < 0) ? -span : span)) / (longint'(200) <<< FRAC);
        drv  = lo_w + ((span < 0) ? -q : q);
        r.drive = drv[31:0];
        return r;
    endfunction

    // input beats feed the predictor
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            pending_drive_q.push_back(predict_actuation(error_sample, clear_first));
    end

    // result beats against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_drive_q.size() == 0)
            begin
                $error("unexpected result beat: drive %h clamped %b", drive, clamped);
                fail_count++;
            end
            else
            begin
                want_beat = pending_drive_q.pop_front();
                if (drive !== want_beat.drive)
                begin
                    $error("drive: expected %h, actual %h", want_beat.drive, drive);
                    fail_count++;
                end
                if (clamped !== want_beat.clamped)
                begin
                    $error("clamped: expected %b, actual %b", want_beat.clamped, clamped);
                    fail_count++;
                end
            end
        end
    end

    // receiver: random stall bursts, plus long holds on request
    initial
    begin : rx_side
        int stall;
        stall = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rx_hold_req > 0)
            begin
                stall       = rx_hold_req;
                rx_hold_req = 0;
            end
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                stall--;
            end
            else if (rx_idle_odds > $urandom_range(0, 7))
            begin
                out_ready <= 1'b0;
                stall = $urandom_range(0, 4);
            end
            else
                out_ready <= 1'b1;
        end
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("TB_ERROR");
        $finish;
    end

    function automatic logic [31:0] rand_span(input int bits);
        logic [31:0] v;
        v = $urandom_range(0, 32'd1 << (bits + 1));
        return v - (32'd1 << bits);
    endfunction

    function automatic logic [31:0] pick_error(input int bits);
        case ($urandom_range(0, 11))
            0: return $urandom;
            1: return 32'h7FFF_FFFF;
            2: return 32'h8000_0000;
            3: return PCT_100;
            4: return PCT_M100;
            default: return rand_span(bits);
        endcase
    endfunction

    // one error beat; valid stays up into the next beat unless a gap follows
    task automatic send_error(input logic [31:0] e, input logic clr);
        in_valid     <= 1'b1;
        error_sample <= e;
        clear_first  <= clr;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (tx_idle_odds > $urandom_range(0, 7))
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
    endtask

    // sender stops until every predicted beat has come back
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_drive_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_KP:     kp_model     = data;
            CFG_KI_TS:  ki_model     = data;
            CFG_KD_TS:  kd_model     = data;
            CFG_OFFSET: offset_model = data[23:0];
            CFG_LOWER:  lower_model  = data;
            CFG_UPPER:  upper_model  = data;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic load_gains(input logic [31:0] kp, input logic [31:0] ki,
                              input logic [31:0] kd, input logic [31:0] off,
                              input logic [31:0] lower, input logic [31:0] upper);
        write_reg(CFG_KP, kp);
        write_reg(CFG_KI_TS, ki);
        write_reg(CFG_KD_TS, kd);
        write_reg(CFG_OFFSET, off);
        write_reg(CFG_LOWER, lower);
        write_reg(CFG_UPPER, upper);
    endtask

    // all registers zero after reset: zero span, drive stays at zero
    task automatic test_reset_state();
        tx_idle_odds = 2;
        rx_idle_odds = 2;
        send_error(32'h7FFF_FFFF, 1'b0);
        send_error(32'h8000_0000, 1'b1);
        send_error(32'h1357_2468, 1'b0);
        wait_idle();
    endtask

    task automatic test_directed_cases();
        // unit gain, map onto -100..100: clamp edges and negative errors
        load_gains(32'h0001_0000, '0, '0, '0, PCT_M100, PCT_100);
        send_error(32'h0000_0000, 1'b1);
        send_error(PCT_100, 1'b0);
        send_error(PCT_100 + 32'd1, 1'b0);
        send_error(PCT_M100, 1'b0);
        send_error(PCT_M100 - 32'd1, 1'b0);
        send_error(32'h7FFF_FFFF, 1'b0);
        send_error(32'h8000_0000, 1'b0);
        send_error(32'hFFFF_FFFF, 1'b0);
        wait_idle();

        // all three terms with offset, reversed limits at full span, clear mid-run
        load_gains(32'h0000_8000, 32'h0000_4000, 32'h0002_0000, 32'h000A_0000,
                   32'h7FFF_FFFF, 32'h8000_0000);
        send_error(32'h0014_0000, 1'b1);
        send_error(32'hFFE2_0000, 1'b0);
        send_error(32'h0005_0000, 1'b0);
        send_error(32'h0007_0000, 1'b1);
        send_error(32'h8000_0000, 1'b0);
        send_error(32'h7FFF_FFFF, 1'b0);
        wait_idle();

        // equal limits, offset beyond +100 with junk in the upper data bits
        load_gains('0, '0, '0, 32'hFF7F_FFFF, 32'h1234_5678, 32'h1234_5678);
        send_error(32'h0000_0000, 1'b1);
        send_error(32'h5555_5555, 1'b0);
        wait_idle();

        // extreme gains, offset beyond -100, unmapped indexes must change nothing
        load_gains(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0080_0000,
                   32'h8000_0000, 32'h7FFF_FFFF);
        write_reg(CFG_UNMAPPED_A, 32'hFFFF_FFFF);
        write_reg(CFG_UNMAPPED_B, 32'hA5A5_A5A5);
        send_error(32'h0000_0001, 1'b1);
        send_error(32'hFFFF_FFFF, 1'b0);
        send_error(32'hAAAA_AAAA, 1'b0);
        send_error(32'h0000_0000, 1'b0);
        wait_idle();
    endtask

    task automatic configure_phase(input phase_kind_t ph);
        logic signed [31:0] a, b;
        a = $urandom;
        b = $urandom;
        case (ph)
            PH_MODERATE:
                load_gains(rand_span(18), rand_span(14), rand_span(16), rand_span(22),
                           $urandom, $urandom);
            PH_OFFSET:
                load_gains(rand_span(18), rand_span(12), rand_span(14), rand_span(23),
                           rand_span(24), rand_span(26));
            PH_WILD:
                load_gains($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
            PH_REVERSED:
                load_gains(rand_span(18), rand_span(14), rand_span(16), rand_span(22),
                           (a > b) ? a : b, (a > b) ? b : a);
            PH_EQUAL:
                load_gains(rand_span(18), rand_span(14), rand_span(16), rand_span(22),
                           a, a);
            default:
                load_gains(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFF7F_FFFF,
                           32'h8000_0000, 32'h7FFF_FFFF);
        endcase
        write_reg(CFG_UNMAPPED_A, $urandom);
        write_reg(CFG_UNMAPPED_B, $urandom);
    endtask

    task automatic test_random_phases();
        phase_kind_t ph;
        int bits;
        for (int p = 0; p < RAND_PHASES; p++)
        begin
            ph = phase_kind_t'(p);
            wait_idle();
            configure_phase(ph);
            tx_idle_odds = $urandom_range(0, 3);
            rx_idle_odds = $urandom_range(0, 3);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (ph == PH_WILD || ph == PH_EXTREME)
                    bits = $urandom_range(0, 30);
                else
                    bits = $urandom_range(4, 23);
                send_error(pick_error(bits), $urandom_range(0, 15) == 0);
            end
        end
        wait_idle();
    endtask

    // receiver holds off while beats keep coming, so the core stalls its input
    task automatic test_output_backpressure();
        load_gains(rand_span(18), rand_span(14), rand_span(16), rand_span(22),
                   PCT_M100, PCT_100);
        tx_idle_odds = 0;
        rx_hold_req  = HOLD_CYCLES;
        repeat (12) send_error(pick_error(20), 1'b0);
        wait_idle();
    endtask

    // drive the error sum into its positive bound; kp cancels the sum so the
    // integrator value stays visible in the percent range near the bound
    task automatic test_sum_saturation();
        tx_idle_odds = 0;
        rx_idle_odds = 0;
        load_gains(32'hFFFF_0000, 32'h0000_0001, '0, '0, PCT_M100, PCT_100);
        send_error(32'h7FFF_FFFF, 1'b1);
        repeat (SAT_ITEMS) send_error(32'h7FFF_FFFF, 1'b0);
        // step back down from the bound
        send_error(32'h8000_0000, 1'b0);
        send_error(32'h8000_0000, 1'b0);
        wait_idle();
    endtask

    initial
    begin
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        error_sample <= '0;
        clear_first  <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_index    <= CFG_KP;
        cfg_wdata    <= '0;
        kp_model     = '0;
        ki_model     = '0;
        kd_model     = '0;
        offset_model = '0;
        lower_model  = '0;
        upper_model  = '0;
        sum_model    = '0;
        prev_model   = '0;
        fail_count   = 0;
        tx_idle_odds = 0;
        rx_idle_odds = 0;
        rx_hold_req  = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_directed_cases();
        test_random_phases();
        test_output_backpressure();
        test_sum_saturation();

        if (fail_count == 0 && pending_drive_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
